FILE: sv/sgd_pkg.sv
// Shared types and constants for the start gesture detector.
// Used by every module of the block; has no dependencies of its own.
`timescale 1ns / 1ps

package sgd_pkg;

    localparam int TimeW  = 48;
    localparam int VelW   = 24;
    localparam int PosW   = 24;
    localparam int LimW   = 23;
    localparam int DurW   = 24;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 24;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_STILL_LIMIT      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN_STILL_TIME   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MAX_STILL_AGE    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MIN_RISE         = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MAX_GESTURE_TIME = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MIN_GESTURE_TIME = 3'd5;

    // Register values after reset
    localparam logic [LimW-1:0] RST_STILL_LIMIT      = 23'd100;
    localparam logic [DurW-1:0] RST_MIN_STILL_TIME   = 24'd100000;
    localparam logic [DurW-1:0] RST_MAX_STILL_AGE    = 24'd1500000;
    localparam logic [LimW-1:0] RST_MIN_RISE         = 23'd50000;
    localparam logic [DurW-1:0] RST_MAX_GESTURE_TIME = 24'd750000;
    localparam logic [DurW-1:0] RST_MIN_GESTURE_TIME = 24'd150000;

    typedef struct packed {
        logic [LimW-1:0] still_limit;
        logic [DurW-1:0] min_still_time;
        logic [DurW-1:0] max_still_age;
        logic [LimW-1:0] min_rise;
        logic [DurW-1:0] max_gesture_time;
        logic [DurW-1:0] min_gesture_time;
    } t_cfg;

    typedef struct packed {
        logic [TimeW-1:0]       time_us;
        logic signed [VelW-1:0] velocity_y;
        logic signed [PosW-1:0] position_y;
        logic                   beat;
    } t_sample;

    typedef struct packed {
        logic             start_found;
        logic [TimeW-1:0] beat_time_us;
        logic [DurW-1:0]  gesture_time_us;
    } t_result;

endpackage

FILE: sv/sgd_still.sv
// Steady period tracker: follows |velocity| against the limit and reports
// whether a long enough steady period ended recently. Depends on sgd_pkg.
`timescale 1ns / 1ps

module sgd_still (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  sgd_pkg::t_cfg    i_cfg,
    input  sgd_pkg::t_sample i_smp,
    output logic             o_steady
);

    logic                           r_in_still;
    logic                           r_end_seen;
    logic [sgd_pkg::TimeW-1:0]      r_start_time;
    logic [sgd_pkg::TimeW-1:0]      r_end_time;

    logic [sgd_pkg::VelW-1:0]       mag;
    logic                           still_now;
    logic [sgd_pkg::TimeW:0]        diff_start;
    logic [sgd_pkg::TimeW:0]        diff_end;
    logic [sgd_pkg::TimeW-1:0]      el_start;
    logic [sgd_pkg::TimeW-1:0]      el_end;
    logic                           end_now;
    logic                           age_ok;

    // Magnitude of the velocity; the most negative value maps to 2^23 exactly
    assign mag = i_smp.velocity_y[sgd_pkg::VelW-1] ?
                 (~i_smp.velocity_y + 24'd1) : i_smp.velocity_y;
    assign still_now = mag < {1'b0, i_cfg.still_limit};

    // Elapsed times, clamped at zero when time runs backward
    assign diff_start = {1'b0, i_smp.time_us} - {1'b0, r_start_time};
    assign diff_end   = {1'b0, i_smp.time_us} - {1'b0, r_end_time};
    assign el_start   = diff_start[sgd_pkg::TimeW] ? '0 : diff_start[sgd_pkg::TimeW-1:0];
    assign el_end     = diff_end[sgd_pkg::TimeW] ? '0 : diff_end[sgd_pkg::TimeW-1:0];

    // A qualifying period ends at this sample
    assign end_now = !still_now && r_in_still &&
                     (el_start >= {24'd0, i_cfg.min_still_time});
    assign age_ok  = el_end <= {24'd0, i_cfg.max_still_age};

    // An end at this sample has age zero and always passes
    assign o_steady = end_now || (r_end_seen && age_ok);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_still <= 1'b0;
            r_end_seen <= 1'b0;
        end else if (i_en) begin
            r_in_still <= still_now;
            if (end_now) begin
                r_end_seen <= 1'b1;
            end
        end
    end

    // Period times; read only once their flags are set
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (still_now && !r_in_still) begin
                r_start_time <= i_smp.time_us;
            end
            if (end_now) begin
                r_end_time <= i_smp.time_us;
            end
        end
    end

endmodule

FILE: sv/sgd_motion.sv
// Beat, bottom and apex tracking plus the start decision for one sample.
// Depends on sgd_pkg; takes the steady verdict from sgd_still.
`timescale 1ns / 1ps

module sgd_motion (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  sgd_pkg::t_cfg    i_cfg,
    input  sgd_pkg::t_sample i_smp,
    input  logic             i_steady,
    output sgd_pkg::t_result o_res
);

    logic signed [sgd_pkg::VelW-1:0] r_last_vel;
    logic                            r_beat_seen;
    logic                            r_bottom_seen;
    logic [sgd_pkg::TimeW-1:0]       r_beat_time;
    logic [sgd_pkg::TimeW-1:0]       r_bottom_time;
    logic signed [sgd_pkg::PosW-1:0] r_bottom_h;

    logic [sgd_pkg::TimeW-1:0]       n_beat_time;
    logic                            n_beat_seen;
    logic                            bottom;
    logic                            apex;
    logic                            order_ok;
    logic signed [sgd_pkg::PosW:0]   rise;
    logic                            rise_ok;
    logic [sgd_pkg::TimeW:0]         len_diff;
    logic [sgd_pkg::TimeW-1:0]       len;
    logic                            len_ok;
    logic                            found;

    // Beat at this sample counts before the decision
    assign n_beat_time = i_smp.beat ? i_smp.time_us : r_beat_time;
    assign n_beat_seen = i_smp.beat || r_beat_seen;

    // Velocity zero crossings
    assign bottom = r_last_vel[sgd_pkg::VelW-1] && !i_smp.velocity_y[sgd_pkg::VelW-1];
    assign apex   = !r_last_vel[sgd_pkg::VelW-1] && (r_last_vel != '0) &&
                    (i_smp.velocity_y[sgd_pkg::VelW-1] || (i_smp.velocity_y == '0));

    // Bottom must come strictly before the beat
    assign order_ok = r_bottom_time < n_beat_time;

    // Rise from bottom, one bit wider so it cannot wrap
    assign rise    = {i_smp.position_y[sgd_pkg::PosW-1], i_smp.position_y}
                   - {r_bottom_h[sgd_pkg::PosW-1], r_bottom_h};
    assign rise_ok = rise >= $signed({2'b00, i_cfg.min_rise});

    // Gesture length inside the window; backward time fails
    assign len_diff = {1'b0, i_smp.time_us} - {1'b0, r_bottom_time};
    assign len      = len_diff[sgd_pkg::TimeW-1:0];
    assign len_ok   = !len_diff[sgd_pkg::TimeW] &&
                      (len <= {24'd0, i_cfg.max_gesture_time}) &&
                      (len >= {24'd0, i_cfg.min_gesture_time});

    // An apex excludes a bottom, so the stored bottom is the one to check
    assign found = apex && i_steady && n_beat_seen && r_bottom_seen &&
                   order_ok && rise_ok && len_ok;

    always_comb begin
        o_res = '0;
        if (found) begin
            o_res.start_found     = 1'b1;
            o_res.beat_time_us    = n_beat_time;
            o_res.gesture_time_us = len[sgd_pkg::DurW-1:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_vel    <= '0;
            r_beat_seen   <= 1'b0;
            r_bottom_seen <= 1'b0;
        end else if (i_en) begin
            r_last_vel  <= i_smp.velocity_y;
            r_beat_seen <= n_beat_seen;
            if (bottom) begin
                r_bottom_seen <= 1'b1;
            end
        end
    end

    // Event times and height; read only once their flags are set
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat_time <= n_beat_time;
            if (bottom) begin
                r_bottom_time <= i_smp.time_us;
                r_bottom_h    <= i_smp.position_y;
            end
        end
    end

endmodule

FILE: sv/start_gesture_detector_core.sv
// Start gesture detector top level: handshakes, configuration, pipeline.
// Depends on sgd_pkg, sgd_still and sgd_motion.
`timescale 1ns / 1ps

// The block takes one motion sample per cycle and returns exactly one result
// per sample, in order. A sample is held in an input register, evaluated
// against the tracked gesture state, and its result lands in an output
// register once the output register is free; while the output side
// keeps taking results the sustained rate is one sample per cycle, set by the
// combinational state update path (48-bit time differences and compares).
// Samples flagged as rolling leave all state alone and return an all-zero
// result. Configuration writes are taken at once and must happen while idle.

module start_gesture_detector_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [sgd_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [sgd_pkg::CfgDataW-1:0]     i_cfg_data,
    // sample channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [sgd_pkg::TimeW-1:0]        i_time_us,
    input  logic signed [sgd_pkg::VelW-1:0]  i_velocity_y,
    input  logic signed [sgd_pkg::PosW-1:0]  i_position_y,
    input  logic                             i_beat,
    input  logic                             i_rolling,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_start_found,
    output logic [sgd_pkg::TimeW-1:0]        o_beat_time_us,
    output logic [sgd_pkg::DurW-1:0]         o_gesture_time_us
);

    sgd_pkg::t_cfg    r_cfg;
    sgd_pkg::t_sample r_smp;
    logic             r_roll;
    logic             r_in_vld;
    sgd_pkg::t_result r_res;
    logic             r_out_vld;

    logic             out_free;
    logic             proc;
    logic             upd_en;
    logic             steady;
    sgd_pkg::t_result res_comb;

    // Pipeline flow
    assign out_free   = !r_out_vld || i_out_ready;
    assign proc       = r_in_vld && out_free;
    assign upd_en     = proc && !r_roll;
    assign o_in_ready = !r_in_vld || out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.still_limit      <= sgd_pkg::RST_STILL_LIMIT;
            r_cfg.min_still_time   <= sgd_pkg::RST_MIN_STILL_TIME;
            r_cfg.max_still_age    <= sgd_pkg::RST_MAX_STILL_AGE;
            r_cfg.min_rise         <= sgd_pkg::RST_MIN_RISE;
            r_cfg.max_gesture_time <= sgd_pkg::RST_MAX_GESTURE_TIME;
            r_cfg.min_gesture_time <= sgd_pkg::RST_MIN_GESTURE_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgd_pkg::CFG_STILL_LIMIT: begin
                    r_cfg.still_limit <= i_cfg_data[sgd_pkg::LimW-1:0];
                end
                sgd_pkg::CFG_MIN_STILL_TIME: begin
                    r_cfg.min_still_time <= i_cfg_data[sgd_pkg::DurW-1:0];
                end
                sgd_pkg::CFG_MAX_STILL_AGE: begin
                    r_cfg.max_still_age <= i_cfg_data[sgd_pkg::DurW-1:0];
                end
                sgd_pkg::CFG_MIN_RISE: begin
                    r_cfg.min_rise <= i_cfg_data[sgd_pkg::LimW-1:0];
                end
                sgd_pkg::CFG_MAX_GESTURE_TIME: begin
                    r_cfg.max_gesture_time <= i_cfg_data[sgd_pkg::DurW-1:0];
                end
                sgd_pkg::CFG_MIN_GESTURE_TIME: begin
                    r_cfg.min_gesture_time <= i_cfg_data[sgd_pkg::DurW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    // Capture the sample on transfer
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_smp.time_us    <= i_time_us;
            r_smp.velocity_y <= i_velocity_y;
            r_smp.position_y <= i_position_y;
            r_smp.beat       <= i_beat;
            r_roll           <= i_rolling;
        end
    end

    sgd_still u_still (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (upd_en),
        .i_cfg    (r_cfg),
        .i_smp    (r_smp),
        .o_steady (steady)
    );

    sgd_motion u_motion (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (upd_en),
        .i_cfg    (r_cfg),
        .i_smp    (r_smp),
        .i_steady (steady),
        .o_res    (res_comb)
    );

    // Output register valid: load on processing, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    // Result payload; rolling samples give an all-zero result
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_res <= r_roll ? '0 : res_comb;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_start_found     = r_res.start_found;
    assign o_beat_time_us    = r_res.beat_time_us;
    assign o_gesture_time_us = r_res.gesture_time_us;

endmodule

FILE: sv/sgd_checker.sv
// Port-level checks for the start gesture detector, bound to the top level.
// Depends on sgd_pkg and start_gesture_detector_core.
`timescale 1ns / 1ps

module sgd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic                             o_start_found,
    input logic [sgd_pkg::TimeW-1:0]        o_beat_time_us,
    input logic [sgd_pkg::DurW-1:0]         o_gesture_time_us
);

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A result without a start carries zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_start_found) |->
        ((o_beat_time_us == '0) && (o_gesture_time_us == '0)))
        else $error("nonzero fields without start");

    // Stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");

    // Stalled result payload holds
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        ($stable(o_start_found) && $stable(o_beat_time_us) &&
         $stable(o_gesture_time_us)))
        else $error("result changed while stalled");

endmodule

bind start_gesture_detector_core sgd_checker u_sgd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_start_found     (o_start_found),
    .o_beat_time_us    (o_beat_time_us),
    .o_gesture_time_us (o_gesture_time_us)
);
